FILE: hw/rtl/stx_pkg.sv
package stx_pkg;

  localparam logic [7:0]  MARK_START = 8'h80;
  localparam logic [7:0]  MARK_END   = 8'h81;
  localparam logic [15:0] CAP_RESET  = 16'd2048;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_ARM  = 1'b1;

  typedef enum logic [2:0] {
    PH_START1 = 3'd0,
    PH_START2 = 3'd1,
    PH_LEN_HI = 3'd2,
    PH_LEN_LO = 3'd3,
    PH_DATA   = 3'd4,
    PH_END1   = 3'd5,
    PH_END2   = 3'd6,
    PH_DONE   = 3'd7
  } phase_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic        write_valid;
    logic [15:0] write_index;
    logic [7:0]  write_byte;
    logic        frame_done;
    logic        frame_error;
  } out_item_t;

endpackage

FILE: hw/rtl/stx_if.sv
interface stx_in_if;
  logic              valid;
  logic              ready;
  stx_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface stx_out_if;
  logic               valid;
  logic               ready;
  stx_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface stx_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/stx_parser.sv
module stx_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  stx_pkg::in_item_t  item,
  input  logic [15:0]        buf_capacity,
  output stx_pkg::out_item_t res
);

  logic             armed_r,  armed_nxt;
  stx_pkg::phase_t  phase_r,  phase_nxt;
  logic [15:0]      len_r,    len_nxt;
  logic [15:0]      count_r,  count_nxt;
  logic             error_r,  error_nxt;
  logic [15:0]      count_inc;

  assign count_inc = count_r + 16'd1;

  always_comb begin
    armed_nxt = armed_r;
    phase_nxt = phase_r;
    len_nxt   = len_r;
    count_nxt = count_r;
    error_nxt = error_r;
    res       = '0;

    if (item.kind == stx_pkg::KIND_ARM) begin
      armed_nxt = 1'b1;
      phase_nxt = stx_pkg::PH_START1;
      len_nxt   = '0;
      count_nxt = '0;
      error_nxt = 1'b0;
    end else if (armed_r) begin
      if (count_r >= buf_capacity) begin
        // overflow: drop byte, phase holds
        error_nxt = 1'b1;
      end else begin
        case (phase_r)
          stx_pkg::PH_START1: begin
            if (item.rx_byte == stx_pkg::MARK_START) phase_nxt = stx_pkg::PH_START2;
          end
          stx_pkg::PH_START2: begin
            phase_nxt = (item.rx_byte == stx_pkg::MARK_START) ? stx_pkg::PH_LEN_HI
                                                              : stx_pkg::PH_START1;
          end
          stx_pkg::PH_LEN_HI: begin
            len_nxt   = {item.rx_byte, 8'h00};
            phase_nxt = stx_pkg::PH_LEN_LO;
          end
          stx_pkg::PH_LEN_LO: begin
            len_nxt   = {len_r[15:8], item.rx_byte};
            phase_nxt = stx_pkg::PH_DATA;
          end
          stx_pkg::PH_DATA: begin
            res.write_valid = 1'b1;
            res.write_index = count_r;
            res.write_byte  = item.rx_byte;
            count_nxt       = count_inc;
            if (len_r <= count_inc) phase_nxt = stx_pkg::PH_END1;
          end
          stx_pkg::PH_END1: begin
            if (item.rx_byte != stx_pkg::MARK_END) error_nxt = 1'b1;
            phase_nxt = stx_pkg::PH_END2;
          end
          stx_pkg::PH_END2: begin
            if (item.rx_byte != stx_pkg::MARK_END) error_nxt = 1'b1;
            phase_nxt = stx_pkg::PH_DONE;
          end
          default: begin
          end
        endcase
      end
      if (phase_nxt == stx_pkg::PH_DONE) armed_nxt = 1'b0;
    end

    res.frame_done  = (phase_nxt == stx_pkg::PH_DONE);
    res.frame_error = error_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r <= 1'b0;
      phase_r <= stx_pkg::PH_START1;
      len_r   <= '0;
      count_r <= '0;
      error_r <= 1'b0;
    end else if (step) begin
      armed_r <= armed_nxt;
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      count_r <= count_nxt;
      error_r <= error_nxt;
    end
  end

  // payload only leaves the data phase
  a_write_in_data: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.write_valid |-> phase_r == stx_pkg::PH_DATA)
    else $error("payload write outside data phase");

  // completion always closes the receiver
  a_done_closed: assert property (@(posedge clk) disable iff (!rst_n)
    !(armed_r && phase_r == stx_pkg::PH_DONE))
    else $error("receiver armed in complete phase");

  a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    step && item.kind == stx_pkg::KIND_BYTE && error_r |-> res.frame_error)
    else $error("error flag dropped without arm");

  a_arm_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step && item.kind == stx_pkg::KIND_ARM
    |=> armed_r && phase_r == stx_pkg::PH_START1 && !error_r && count_r == 16'd0)
    else $error("arm did not clear parser");

endmodule

FILE: hw/rtl/stx_etx_length_frame_receiver.sv
// Path: input register, then result register, between input transfer and result transfer.
// Throughput: one byte or arm item per cycle while the result sink takes results; a stalled
//   result register holds the input register and with it the input channel.
// Reset (rst_n low, synchronous): receiver closed, hunting first start mark, counters
//   and error cleared, buf_capacity back to 2048, both pipeline stages empty.
module stx_etx_length_frame_receiver (
  input  logic      clk,
  input  logic      rst_n,
  stx_in_if.sink    in_chan,
  stx_out_if.source out_chan,
  stx_cfg_if.sink   cfg_chan
);

  // capacity register; config is always taken
  logic [15:0] buf_capacity_r;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_capacity_r <= stx_pkg::CAP_RESET;
    end else if (cfg_chan.valid) begin
      buf_capacity_r <= cfg_chan.data;
    end
  end

  // input stage
  logic               s0_valid_r, s0_valid_nxt;
  stx_pkg::in_item_t  s0_item_r;
  logic               out_valid_r, out_valid_nxt;
  stx_pkg::out_item_t out_item_r;
  stx_pkg::out_item_t res;
  logic               in_xfer;
  logic               step;

  // step: the held item moves into the result register, parser state updates
  assign step          = s0_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s0_valid_r || step;
  assign in_xfer       = in_chan.valid && in_chan.ready;

  assign s0_valid_nxt  = in_xfer || (s0_valid_r && !step);
  assign out_valid_nxt = step || (out_valid_r && !out_chan.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s0_valid_r  <= s0_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) s0_item_r  <= in_chan.data;
    if (step)    out_item_r <= res;
  end

  stx_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .item         (s0_item_r),
    .buf_capacity (buf_capacity_r),
    .res          (res)
  );

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_item_r;

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps

module tb;

  // Run limits. Even with the slowest flow setting the cycle ceiling sits far above
  // any correct run.
  localparam int unsigned        LIMIT_CYCLES = 400000;
  localparam int unsigned        HOLD_LEN     = 300;  // long sink hold-off, fills the pipe
  localparam int unsigned        DRAIN_CYCLES = 6;    // two-stage pipe plus margin
  localparam stx_pkg::out_item_t QUIET        = '0;   // no write, not done, no error

  typedef enum logic [1:0] {
    FLOW_FREE,
    FLOW_SRC_IDLE,
    FLOW_SINK_STALL,
    FLOW_BOTH
  } flow_t;

  // Directed row: one input item and, where obvious, the result it must give.
  typedef struct packed {
    logic               kind;
    logic [7:0]         rx_byte;
    logic               typed;
    stx_pkg::out_item_t want;
  } dir_row_t;

  logic clk;
  logic rst_n;

  stx_in_if  in_if ();
  stx_out_if out_if ();
  stx_cfg_if cfg_if ();

  stx_etx_length_frame_receiver u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_if),
    .out_chan(out_if),
    .cfg_chan(cfg_if)
  );

  // Side-band to the monitor: a typed expectation travelling with the offered item.
  logic               in_typed;
  stx_pkg::out_item_t in_want;

  flow_t       flow;
  int unsigned hold_reqs   = 0;
  int unsigned hold_seen   = 0;
  int unsigned hold_left   = 0;
  int unsigned cycles      = 0;
  int unsigned faults      = 0;
  int unsigned phase_sent  = 0;

  // Frame parser mirror: state and capacity as the block should hold them.
  logic               rx_open;
  stx_pkg::phase_t    rx_phase;
  logic [15:0]        rx_len;
  logic [15:0]        rx_count;
  logic [15:0]        rx_cap;
  logic               rx_err;
  stx_pkg::out_item_t rx_reports [$];
  stx_pkg::out_item_t seen;
  stx_pkg::out_item_t due;

  // Directed part: closed receiver, both start-mark faults, zero length, an end mark
  // inside the payload, wrong end mark, byte after completion, maximum length
  // and an arm that cuts a frame short.
  dir_row_t dir_tab [0:28] = '{
    '{stx_pkg::KIND_BYTE, 8'hFF, 1'b1, QUIET},                         // closed
    '{stx_pkg::KIND_ARM,  8'h00, 1'b1, QUIET},
    '{stx_pkg::KIND_BYTE, 8'h7F, 1'b0, QUIET},                         // not a mark
    '{stx_pkg::KIND_BYTE, stx_pkg::MARK_START, 1'b0, QUIET},
    '{stx_pkg::KIND_BYTE, 8'h55, 1'b0, QUIET},                         // bad 2nd mark
    '{stx_pkg::KIND_BYTE, stx_pkg::MARK_START, 1'b0, QUIET},
    '{stx_pkg::KIND_BYTE, stx_pkg::MARK_START, 1'b0, QUIET},
    '{stx_pkg::KIND_BYTE, 8'h00, 1'b0, QUIET},
    '{stx_pkg::KIND_BYTE, 8'h00, 1'b0, QUIET},                         // length 0
    // length 0 still takes one byte
    '{stx_pkg::KIND_BYTE, 8'hFF, 1'b1, {1'b1, 16'd0, 8'hFF, 1'b0, 1'b0}},
    '{stx_pkg::KIND_BYTE, stx_pkg::MARK_END, 1'b0, QUIET},
    '{stx_pkg::KIND_BYTE, stx_pkg::MARK_END, 1'b1, {1'b0, 16'd0, 8'h00, 1'b1, 1'b0}},
    // byte after completion
    '{stx_pkg::KIND_BYTE, stx_pkg::MARK_START, 1'b1, {1'b0, 16'd0, 8'h00, 1'b1, 1'b0}},
    '{stx_pkg::KIND_ARM,  8'hFF, 1'b1, QUIET},
    '{stx_pkg::KIND_BYTE, stx_pkg::MARK_START, 1'b0, QUIET},
    '{stx_pkg::KIND_BYTE, stx_pkg::MARK_START, 1'b0, QUIET},
    '{stx_pkg::KIND_BYTE, 8'h00, 1'b0, QUIET},
    '{stx_pkg::KIND_BYTE, 8'h02, 1'b0, QUIET},
    '{stx_pkg::KIND_BYTE, 8'h00, 1'b1, {1'b1, 16'd0, 8'h00, 1'b0, 1'b0}},
    '{stx_pkg::KIND_BYTE, stx_pkg::MARK_END, 1'b0, QUIET},             // mark as data
    '{stx_pkg::KIND_BYTE, 8'h00, 1'b1, {1'b0, 16'd0, 8'h00, 1'b0, 1'b1}}, // bad end mark
    '{stx_pkg::KIND_BYTE, stx_pkg::MARK_END, 1'b1, {1'b0, 16'd0, 8'h00, 1'b1, 1'b1}},
    '{stx_pkg::KIND_ARM,  8'h00, 1'b1, QUIET},                         // clears error
    '{stx_pkg::KIND_BYTE, stx_pkg::MARK_START, 1'b0, QUIET},
    '{stx_pkg::KIND_BYTE, stx_pkg::MARK_START, 1'b0, QUIET},
    '{stx_pkg::KIND_BYTE, 8'hFF, 1'b0, QUIET},
    '{stx_pkg::KIND_BYTE, 8'hFF, 1'b0, QUIET},                         // length 65535
    '{stx_pkg::KIND_BYTE, 8'h5A, 1'b0, QUIET},
    '{stx_pkg::KIND_ARM,  8'h00, 1'b1, QUIET}                          // mid-frame arm
  };

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // One parser step for one accepted item; updates the mirror state.
  function automatic stx_pkg::out_item_t parse_rx(stx_pkg::in_item_t it);
    stx_pkg::out_item_t r;
    r = '0;
    if (it.kind == stx_pkg::KIND_ARM) begin
      rx_open  = 1'b1;
      rx_phase = stx_pkg::PH_START1;
      rx_len   = '0;
      rx_count = '0;
      rx_err   = 1'b0;
    end else if (rx_open) begin
      if (rx_count >= rx_cap) begin
        // buffer full: any byte, marks included, is dropped and flagged
        rx_err = 1'b1;
      end else begin
        case (rx_phase)
          stx_pkg::PH_START1: begin
            if (it.rx_byte == stx_pkg::MARK_START) rx_phase = stx_pkg::PH_START2;
          end
          stx_pkg::PH_START2: begin
            if (it.rx_byte == stx_pkg::MARK_START) rx_phase = stx_pkg::PH_LEN_HI;
            else rx_phase = stx_pkg::PH_START1;
          end
          stx_pkg::PH_LEN_HI: begin
            rx_len   = {it.rx_byte, 8'h00};
            rx_phase = stx_pkg::PH_LEN_LO;
          end
          stx_pkg::PH_LEN_LO: begin
            rx_len   = rx_len | {8'h00, it.rx_byte};
            rx_phase = stx_pkg::PH_DATA;
          end
          stx_pkg::PH_DATA: begin
            r.write_valid = 1'b1;
            r.write_index = rx_count;
            r.write_byte  = it.rx_byte;
            rx_count      = rx_count + 16'd1;
            if (rx_len <= rx_count) rx_phase = stx_pkg::PH_END1;
          end
          stx_pkg::PH_END1: begin
            if (it.rx_byte != stx_pkg::MARK_END) rx_err = 1'b1;
            rx_phase = stx_pkg::PH_END2;
          end
          stx_pkg::PH_END2: begin
            if (it.rx_byte != stx_pkg::MARK_END) rx_err = 1'b1;
            rx_phase = stx_pkg::PH_DONE;
          end
          default: ;
        endcase
        if (rx_phase == stx_pkg::PH_DONE) rx_open = 1'b0;
      end
    end
    r.frame_done  = (rx_phase == stx_pkg::PH_DONE);
    r.frame_error = rx_err;
    return r;
  endfunction

  task automatic log_fault(string msg);
    $display("%0t ns MISMATCH %s", $time, msg);
    faults++;
  endtask

  // Offer one item on the input channel; returns at the falling edge after the
  // transfer, with valid still high so back-to-back items need no gap.
  task automatic offer(logic kind, logic [7:0] b, logic typed = 1'b0,
                       stx_pkg::out_item_t want = '0);
    int unsigned idle_pct;
    idle_pct = (flow == FLOW_SRC_IDLE) ? 78 : (flow == FLOW_BOTH) ? 11 : 0;
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= {kind, b};
    in_typed    <= typed;
    in_want     <= want;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    phase_sent++;
    @(negedge clk);
  endtask

  task automatic set_capacity(logic [15:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Stop offering, let every outstanding result arrive, then let the pipe settle.
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (rx_reports.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Result sink: random stalls per flow setting, plus an occasional long
  // hold-off counted here so the sender keeps pushing into a blocked pipe.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_if.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_reqs != hold_seen) begin
      hold_seen    <= hold_reqs;
      hold_left    <= HOLD_LEN;
      out_if.ready <= 1'b0;
    end else if (flow == FLOW_SINK_STALL) begin
      out_if.ready <= ($urandom_range(99) >= 78);
    end else if (flow == FLOW_BOTH) begin
      out_if.ready <= ($urandom_range(99) >= 11);
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Monitor: all three channels sampled at the rising edge in one process, so the
  // mirror, the queue and the checks never race one another.
  always @(posedge clk) begin
    if (!rst_n) begin
      rx_open  = 1'b0;
      rx_phase = stx_pkg::PH_START1;
      rx_len   = '0;
      rx_count = '0;
      rx_err   = 1'b0;
      rx_cap   = stx_pkg::CAP_RESET;
      rx_reports.delete();
    end else begin
      if (cfg_if.valid && cfg_if.ready) rx_cap = cfg_if.data;
      if (out_if.valid && out_if.ready) begin
        seen = out_if.data;
        if (rx_reports.size() == 0) begin
          log_fault($sformatf("result %h with nothing outstanding", seen));
        end else begin
          due = rx_reports.pop_front();
          if (seen.write_valid !== due.write_valid)
            log_fault($sformatf("write_valid %b, want %b", seen.write_valid,
                                due.write_valid));
          if (seen.write_index !== due.write_index)
            log_fault($sformatf("write_index %0d, want %0d", seen.write_index,
                                due.write_index));
          if (seen.write_byte !== due.write_byte)
            log_fault($sformatf("write_byte %h, want %h", seen.write_byte,
                                due.write_byte));
          if (seen.frame_done !== due.frame_done)
            log_fault($sformatf("frame_done %b, want %b", seen.frame_done,
                                due.frame_done));
          if (seen.frame_error !== due.frame_error)
            log_fault($sformatf("frame_error %b, want %b", seen.frame_error,
                                due.frame_error));
        end
      end
      // the mirror always steps; a typed row replaces only what is queued
      if (in_if.valid && in_if.ready) begin
        due = parse_rx(in_if.data);
        rx_reports.push_back(in_typed ? in_want : due);
      end
    end
  end

  // Watchdog on the whole run.
  initial begin
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("stx_etx_length_frame_receiver regression: fail");
    $finish;
  end

  initial begin
    int unsigned p;
    int unsigned budget;
    int unsigned n;
    int unsigned k;
    logic [15:0] cap_new;
    logic [15:0] len;
    bit          trunc;

    rst_n        = 1'b0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    in_typed     = 1'b0;
    in_want      = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    flow         = FLOW_FREE;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // directed rows at the reset capacity
    foreach (dir_tab[i])
      offer(dir_tab[i].kind, dir_tab[i].rx_byte, dir_tab[i].typed, dir_tab[i].want);

    // random phases: capacity extremes and small buffers for overflow, the
    // phases cycling through the four flow settings in turn
    for (p = 0; p < 8; p++) begin
      wait_idle();
      flow <= flow_t'(p % 4);
      case (p)
        0:       cap_new = 16'hFFFF;
        1:       cap_new = 16'd1;
        2:       cap_new = 16'd0;
        3:       cap_new = 16'd5;
        4:       cap_new = 16'd24;
        5:       cap_new = 16'($urandom_range(1, 64));
        6:       cap_new = stx_pkg::CAP_RESET;
        default: cap_new = 16'($urandom_range(1, 65535));
      endcase
      set_capacity(cap_new);
      budget     = (cap_new == 0) ? 60 : 255;
      phase_sent = 0;
      // free-flow phases open with a long sink hold-off
      if (p % 4 == 0) hold_reqs <= hold_reqs + 1;

      while (phase_sent < budget) begin
        if ($urandom_range(99) < 8) begin
          // noise: stray bytes and arms
          repeat ($urandom_range(1, 4))
            offer(($urandom_range(3) == 0) ? stx_pkg::KIND_ARM : stx_pkg::KIND_BYTE,
                  8'($urandom));
        end else begin
          if ($urandom_range(19) != 0) offer(stx_pkg::KIND_ARM, 8'($urandom));
          if ($urandom_range(9) == 0) offer(stx_pkg::KIND_BYTE, 8'($urandom));
          offer(stx_pkg::KIND_BYTE, stx_pkg::MARK_START);
          offer(stx_pkg::KIND_BYTE,
                ($urandom_range(19) == 0) ? 8'($urandom) : stx_pkg::MARK_START);
          trunc = ($urandom_range(19) == 0);
          k     = $urandom_range(9);
          if (trunc) len = 16'($urandom);
          else if (k == 0) len = 16'($urandom_range(300));
          else if (k < 3 && cap_new < 100) len = 16'($urandom_range(cap_new + 2));
          else len = 16'($urandom_range(12));
          offer(stx_pkg::KIND_BYTE, len[15:8]);
          offer(stx_pkg::KIND_BYTE, len[7:0]);
          n = (len == 0) ? 1 : len;
          k = $urandom_range(11);
          if (trunc) n = $urandom_range(1, 6);
          else if (k == 0) n = n + 1;
          else if (k == 1 && n > 1) n = n - 1;
          repeat (n) offer(stx_pkg::KIND_BYTE, 8'($urandom));
          // a cut-short frame is left for the next arm to abandon
          if (!trunc) begin
            offer(stx_pkg::KIND_BYTE,
                  ($urandom_range(19) == 0) ? 8'($urandom) : stx_pkg::MARK_END);
            offer(stx_pkg::KIND_BYTE,
                  ($urandom_range(19) == 0) ? 8'($urandom) : stx_pkg::MARK_END);
            if ($urandom_range(9) == 0) offer(stx_pkg::KIND_BYTE, 8'($urandom));
          end
        end
      end
    end

    wait_idle();
    if (faults == 0) begin
      $display("stx_etx_length_frame_receiver regression: pass");
    end else begin
      $display("stx_etx_length_frame_receiver regression: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/stx_pkg.sv
hw/rtl/stx_if.sv
hw/rtl/stx_parser.sv
hw/rtl/stx_etx_length_frame_receiver.sv
sim/tb.sv
